FILE: design/ptc_pkg.sv
package ptc_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_TEMP_CAL = 2'd0;
	localparam logic [1:0] REG_PRESS_A  = 2'd1;
	localparam logic [1:0] REG_PRESS_B  = 2'd2;
	localparam logic [1:0] REG_PRESS_C  = 2'd3;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned DEN_W     = 31;

	// Sideband that rides alongside the divider.
	typedef struct packed {
		logic [15:0] temp;
		logic        neg;
		logic        invalid;
	} ptc_side_t;

	// Low 64 bits of a 64-bit word times a 17-bit signed coefficient,
	// built from a 33x17 and a 32x17 partial product.
	function automatic logic [63:0] mul_lo64(input logic [63:0] x, input logic [16:0] c);
		logic signed [49:0] lo;
		logic [31:0]        hi;
		lo = $signed({1'b0, x[31:0]}) * $signed(c);
		hi = 32'($signed(x[63:32]) * $signed(c));
		return 64'(lo) + {hi, 32'b0};
	endfunction

endpackage

FILE: design/ptc_div.sv
module ptc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [63:0]                     num,
	input  logic [ptc_pkg::DEN_W-1:0]       den,
	input  ptc_pkg::ptc_side_t              side_in,
	output logic                            out_valid,
	output logic [63:0]                     quo,
	output ptc_pkg::ptc_side_t              side_out
);

	localparam int unsigned N = ptc_pkg::DIV_STEPS;

	logic                            vld_s  [N];
	logic [ptc_pkg::DEN_W-1:0]       rem_s  [N];
	logic [63:0]                     num_s  [N];
	logic [ptc_pkg::DEN_W-1:0]       den_s  [N];
	ptc_pkg::ptc_side_t              side_s [N];

	logic [ptc_pkg::DEN_W-1:0]       rem_nxt [N];
	logic [63:0]                     num_nxt [N];

	// One restoring step per stage: the numerator shifts out at the top while
	// the quotient bits shift in at the bottom of the same word.
	always_comb begin
		for (int k = 0; k < N; k++) begin
			logic [ptc_pkg::DEN_W-1:0] r;
			logic [63:0]               n;
			logic [ptc_pkg::DEN_W:0]   t;
			logic [ptc_pkg::DEN_W-1:0] d;
			if (k == 0) begin
				r = '0;
				n = num;
				d = den;
			end else begin
				r = rem_s[k-1];
				n = num_s[k-1];
				d = den_s[k-1];
			end
			t = {r, n[63]};
			if (t >= {1'b0, d}) begin
				rem_nxt[k] = ptc_pkg::DEN_W'(t - {1'b0, d});
				num_nxt[k] = {n[62:0], 1'b1};
			end else begin
				rem_nxt[k] = t[ptc_pkg::DEN_W-1:0];
				num_nxt[k] = {n[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < N; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_nxt[k];
				num_s[k] <= num_nxt[k];
			end
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign quo       = num_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

FILE: design/pressure_temperature_compensation_top.sv
// Integer compensation of a combined barometric and temperature sensor. Each input beat
// carries the six raw register bytes of one sample; each output beat gives the temperature
// in hundredths of a degree (saturated to 16 bits), the pressure in whole pascals and a flag
// that is set, with the pressure forced to zero, when the pressure divisor is zero. One beat
// is accepted every cycle while the output is not stalled. From acceptance to the result the pipeline has
// 12 stages of temperature and calibration arithmetic, 64 stages of a bit-per-stage
// restoring divider, and 5 stages of pressure correction including the output register.
// Back-pressure on the output stalls the whole pipeline. Calibration words must be written
// while the pipeline holds no samples.
module pressure_temperature_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// temperature_centi, pressure_pa
	output logic [39:0] m_tdata,
	// pressure_invalid
	output logic [0:0]  m_tuser
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q  <= '0;
			press_b_q  <= '0;
			press_c_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				ptc_pkg::REG_TEMP_CAL: temp_cal_q <= wr_data[47:0];
				ptc_pkg::REG_PRESS_A:  press_a_q  <= wr_data;
				ptc_pkg::REG_PRESS_B:  press_b_q  <= wr_data;
				ptc_pkg::REG_PRESS_C:  press_c_q  <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_cal_q[15:0];
	assign t2 = $signed(temp_cal_q[31:16]);
	assign t3 = $signed(temp_cal_q[47:32]);
	assign p1 = press_a_q[15:0];
	assign p2 = $signed(press_a_q[31:16]);
	assign p3 = $signed(press_a_q[47:32]);
	assign p4 = $signed(press_a_q[63:48]);
	assign p5 = $signed(press_b_q[15:0]);
	assign p6 = $signed(press_b_q[31:16]);
	assign p7 = $signed(press_b_q[47:32]);
	assign p8 = $signed(press_b_q[63:48]);
	assign p9 = $signed(press_c_q);

	logic en, m_valid_q;
	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_valid_q;

	logic [19:0] adc_t, adc_p;
	assign adc_p = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:20]};
	assign adc_t = {s_tdata[31:24], s_tdata[39:32], s_tdata[47:44]};

	// Valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			{vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15} <= '0;
			vld_s16   <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			vld_s11   <= vld_s10;
			vld_s12   <= vld_s11;
			vld_s13   <= div_vld;
			vld_s14   <= vld_s13;
			vld_s15   <= vld_s14;
			vld_s16   <= vld_s15;
			m_valid_q <= vld_s16;
		end
	end

	// Temperature and calibration datapath.
	logic signed [17:0] a_s1;
	logic signed [16:0] d_s1;
	logic [19:0]        adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [19:0]        adcp_s8, adcp_s9;
	logic signed [33:0] m1_s2, dd_s2;
	logic signed [22:0] x1_s3;
	logic signed [37:0] y_s3;
	logic signed [25:0] tfine_s4;
	logic [15:0]        temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic signed [26:0] pv1_s5;
	logic signed [53:0] sq_s6;
	logic signed [42:0] m5_s6, m2_s6, m5_s7, m2_s7;
	logic [63:0]        a6_s7, a3_s7, v2_s8, w_s8, v2_s9, z_s9, n0_s10, n_s11;
	logic signed [30:0] den_s10, den_s11;
	logic [63:0]        mn_s12;
	logic [30:0]        md_s12;
	ptc_pkg::ptc_side_t side_s12;

	logic signed [21:0] dd_sh;
	logic signed [28:0] tf5;
	logic signed [20:0] tcent;
	logic [15:0]        tsat;
	logic [20:0]        pp;

	always_comb begin
		dd_sh = 22'(dd_s2 >>> 12);
		tf5   = 29'(tfine_s4) * 29'sd5 + 29'sd128;
		tcent = 21'(tf5 >>> 8);
		if (tcent < -21'sd32768)     tsat = 16'h8000;
		else if (tcent > 21'sd32767) tsat = 16'h7FFF;
		else                         tsat = tcent[15:0];
		pp = 21'd1048576 - {1'b0, adcp_s9};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
			d_s1     <= $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
			adcp_s1  <= adc_p;

			m1_s2    <= a_s1 * t2;
			dd_s2    <= d_s1 * d_s1;
			adcp_s2  <= adcp_s1;

			x1_s3    <= 23'(m1_s2 >>> 11);
			y_s3     <= dd_sh * t3;
			adcp_s3  <= adcp_s2;

			tfine_s4 <= 26'(x1_s3) + 26'(y_s3 >>> 14);
			adcp_s4  <= adcp_s3;

			temp_s5  <= tsat;
			pv1_s5   <= 27'(tfine_s4) - 27'sd128000;
			adcp_s5  <= adcp_s4;

			sq_s6    <= pv1_s5 * pv1_s5;
			m5_s6    <= pv1_s5 * p5;
			m2_s6    <= pv1_s5 * p2;
			temp_s6  <= temp_s5;
			adcp_s6  <= adcp_s5;

			a6_s7    <= ptc_pkg::mul_lo64(64'(sq_s6), {p6[15], p6});
			a3_s7    <= ptc_pkg::mul_lo64(64'(sq_s6), {p3[15], p3});
			m5_s7    <= m5_s6;
			m2_s7    <= m2_s6;
			temp_s7  <= temp_s6;
			adcp_s7  <= adcp_s6;

			v2_s8    <= a6_s7 + (64'(m5_s7) << 17) + (64'(p4) << 35);
			w_s8     <= 64'($signed(a3_s7) >>> 8) + (64'(m2_s7) << 12);
			temp_s8  <= temp_s7;
			adcp_s8  <= adcp_s7;

			z_s9     <= ptc_pkg::mul_lo64(64'h0000_8000_0000_0000 + w_s8, {1'b0, p1});
			v2_s9    <= v2_s8;
			temp_s9  <= temp_s8;
			adcp_s9  <= adcp_s8;

			den_s10  <= 31'($signed(z_s9) >>> 33);
			n0_s10   <= ({43'b0, pp} << 31) - v2_s9;
			temp_s10 <= temp_s9;

			n_s11    <= n0_s10 * 64'd3125;
			den_s11  <= den_s10;
			temp_s11 <= temp_s10;

			mn_s12           <= n_s11[63] ? (64'd0 - n_s11) : n_s11;
			md_s12           <= den_s11[30] ? 31'(-den_s11) : den_s11;
			side_s12.temp    <= temp_s11;
			side_s12.neg     <= n_s11[63] ^ den_s11[30];
			side_s12.invalid <= (den_s11 == '0);
		end
	end

	logic [63:0]        quo;
	ptc_pkg::ptc_side_t div_side;

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s12),
		.num      (mn_s12),
		.den      (md_s12),
		.side_in  (side_s12),
		.out_valid(div_vld),
		.quo      (quo),
		.side_out (div_side)
	);

	// Second-order pressure correction.
	logic [63:0]        p_s13, p_s14, p_s15, p_s16;
	logic [63:0]        ll_s14, lh_s14, v2m_s14, sqa_s15, v2_s15, v2_s16, v1_s16;
	ptc_pkg::ptc_side_t side_s13, side_s14, side_s15, side_s16;
	logic [63:0]        pa13;
	logic [63:0]        sum16, pcomp, pa;
	logic [23:0]        press_sat;

	assign pa13 = 64'($signed(p_s13) >>> 13);

	always_comb begin
		sum16 = 64'($signed(p_s16 + v1_s16 + v2_s16) >>> 8) + (64'(p7) << 4);
		pcomp = 64'($signed(sum16) >>> 8);
		pa    = pcomp;
		if (side_s16.invalid || pa[63]) press_sat = '0;
		else if (pa[63:24] != '0)       press_sat = 24'hFF_FFFF;
		else                            press_sat = pa[23:0];
	end

	logic [15:0] temp_q;
	logic [23:0] press_q;
	logic        invalid_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s13    <= div_side.neg ? (64'd0 - quo) : quo;
			side_s13 <= div_side;

			ll_s14   <= pa13[31:0] * pa13[31:0];
			lh_s14   <= pa13[31:0] * pa13[63:32];
			v2m_s14  <= ptc_pkg::mul_lo64(p_s13, {p8[15], p8});
			p_s14    <= p_s13;
			side_s14 <= side_s13;

			sqa_s15  <= ll_s14 + {lh_s14[30:0], 33'b0};
			v2_s15   <= 64'($signed(v2m_s14) >>> 19);
			p_s15    <= p_s14;
			side_s15 <= side_s14;

			v1_s16   <= 64'($signed(ptc_pkg::mul_lo64(sqa_s15, {p9[15], p9})) >>> 25);
			v2_s16   <= v2_s15;
			p_s16    <= p_s15;
			side_s16 <= side_s15;

			temp_q    <= side_s16.temp;
			press_q   <= press_sat;
			invalid_q <= side_s16.invalid;
		end
	end

	assign m_tdata = {press_q, temp_q};
	assign m_tuser = invalid_q;

`ifndef SYNTH
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[39:16] == 24'd0)
		else $error("invalid result carries a non-zero pressure");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register is empty");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while the pipeline is stalled");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s16) && $stable(vld_s1))
		else $error("pipeline moved during a stall");
`endif

endmodule
